// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define FSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define FSR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/fsr_pkg.sv =====
`timescale 1ns / 1ps

package fsr_pkg;

    localparam int NUM_LINES_DEF       = 18;
    localparam int LINES_PER_FRAME_DEF = 3;
    localparam int TIME_BITS_DEF       = 16;

    localparam int IDX_W = 5;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_ACCESS = 2'd2,
        MODE_EVICT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FRAME = 2'd1,
        STATUS_BAD_LINE = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/fsr_if.sv =====
`timescale 1ns / 1ps

interface fsr_req_if;
    logic                     valid;
    logic                     ready;
    fsr_pkg::mode_t           mode;
    logic [fsr_pkg::IDX_W-1:0] line_index;

    modport source (output valid, output mode, output line_index, input ready);
    modport sink   (input valid, input mode, input line_index, output ready);
endinterface

interface fsr_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [fsr_pkg::IDX_W-1:0] result_index;
    fsr_pkg::status_t         status;

    modport source (output valid, output result_index, output status, input ready);
    modport sink   (input valid, input result_index, input status, output ready);
endinterface

interface fsr_cfg_if;
    logic valid;
    logic ready;
    logic replacement_policy;

    modport source (output valid, output replacement_policy, input ready);
    modport sink   (input valid, input replacement_policy, output ready);
endinterface

// ===== hw/rtl/frame_store_replacement_top.sv =====
// Flow: fill/access read the frame row and write it back (S_RMW); find and evict scan the
// frames (S_SCAN), evict then writes the victim (S_EVICT); all results register from S_DONE.
// Throughput: one request at a time; the next transfer is taken once the result is
// registered, later while a previous result is held off; searches read one frame a cycle.
// Reset: rst_n asynchronous active low; clears control, access clock, policy and the
// per-frame valid bits at once (unwritten frames read as zero), no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_store_replacement_top #(
    parameter int NUM_LINES       = fsr_pkg::NUM_LINES_DEF,
    parameter int LINES_PER_FRAME = fsr_pkg::LINES_PER_FRAME_DEF,
    parameter int TIME_BITS       = fsr_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fsr_cfg_if.sink   cfg,
    fsr_req_if.sink   req,
    fsr_rsp_if.source rsp
);

    localparam int NUM_FRAMES = NUM_LINES / LINES_PER_FRAME;
    localparam int FULL_LINES = NUM_FRAMES * LINES_PER_FRAME;
    localparam int MEM_DEPTH  = (NUM_FRAMES > 0) ? NUM_FRAMES : 1;
    localparam int FRAME_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MEM_DEPTH + 1);
    localparam int OFF_W      = (LINES_PER_FRAME > 1) ? $clog2(LINES_PER_FRAME) : 1;
    localparam int LINE_W     = $clog2(NUM_LINES + 1);
    localparam int ROW_W      = LINES_PER_FRAME + 2 * TIME_BITS;
    localparam int SUM_W      = TIME_BITS + 4;
    localparam int LUT_N      = 2 ** fsr_pkg::IDX_W;
    localparam logic [TIME_BITS-1:0] CLOCK_MAX = '1;
    localparam logic [FRAME_W-1:0]   LAST_FRAME = FRAME_W'(MEM_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_EVICT,
        S_DONE
    } state_t;

    // line -> frame / offset tables
    logic [FRAME_W-1:0] frame_lut [LUT_N];
    logic [OFF_W-1:0]   off_lut   [LUT_N];

    for (genvar i = 0; i < LUT_N; i++) begin : g_lut
        assign frame_lut[i] = FRAME_W'(i / LINES_PER_FRAME);
        assign off_lut[i]   = OFF_W'(i % LINES_PER_FRAME);
    end

    // frame table: {used bits, access time and load time of first line}
    logic [ROW_W-1:0] mem [MEM_DEPTH];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic             wr_en;
    logic [FRAME_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    logic [MEM_DEPTH-1:0] row_valid_reg, row_valid_next;

    state_t                    state_reg, state_next;
    fsr_pkg::mode_t            mode_reg, mode_next;
    logic [fsr_pkg::IDX_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                      rd_pend_reg;
    logic                      rd_valid_reg;
    logic [FRAME_W-1:0]        rd_addr_q_reg;
    logic [FRAME_W-1:0]        best_reg, best_next;
    logic [TIME_BITS-1:0]      best_time_reg, best_time_next;
    logic                      best_ok_reg, best_ok_next;
    logic [fsr_pkg::IDX_W-1:0] res_reg, res_next;
    fsr_pkg::status_t          status_reg, status_next;
    logic [TIME_BITS-1:0]      clock_reg, clock_next;
    logic                      policy_reg, policy_next;
    logic                      out_valid_reg, out_valid_next;
    logic [fsr_pkg::IDX_W-1:0] out_index_reg, out_index_next;
    fsr_pkg::status_t          out_status_reg, out_status_next;

    logic [ROW_W-1:0]           row;
    logic [LINES_PER_FRAME-1:0] row_used, new_used;
    logic [TIME_BITS-1:0]       row_acc, row_load, new_acc, new_load, cand_time;
    logic [SUM_W-1:0]           inc_one, inc_frame;
    logic [TIME_BITS-1:0]       stamp_one, stamp_frame;
    logic                       req_xfer;
    logic                       scan_last;
    logic [OFF_W-1:0]           off;
    logic                       bad_line_done;
    logic                       line_mode;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.status       = out_status_reg;

    assign req_xfer = req.valid && (state_reg == S_IDLE);

    assign row      = rd_valid_reg ? rd_data_reg : '0;
    assign row_used = row[ROW_W-1 -: LINES_PER_FRAME];
    assign row_acc  = row[2*TIME_BITS-1 -: TIME_BITS];
    assign row_load = row[TIME_BITS-1:0];

    // saturating clock stamps
    assign inc_one     = SUM_W'(clock_reg) + SUM_W'(1);
    assign inc_frame   = SUM_W'(clock_reg) + SUM_W'(LINES_PER_FRAME);
    assign stamp_one   = (inc_one > SUM_W'(CLOCK_MAX)) ? CLOCK_MAX : inc_one[TIME_BITS-1:0];
    assign stamp_frame = (inc_frame > SUM_W'(CLOCK_MAX)) ? CLOCK_MAX
                                                         : inc_frame[TIME_BITS-1:0];

    assign cand_time = policy_reg ? row_load : row_acc;
    assign scan_last = rd_pend_reg && (rd_addr_q_reg == LAST_FRAME);
    assign off       = off_lut[line_reg];

    assign bad_line_done = (state_reg == S_DONE) && (status_reg == fsr_pkg::STATUS_BAD_LINE);
    assign line_mode     = (mode_reg == fsr_pkg::MODE_FILL) || (mode_reg == fsr_pkg::MODE_ACCESS);

    function automatic logic [fsr_pkg::IDX_W-1:0] frame_base(input logic [FRAME_W-1:0] f);
        logic [LINE_W-1:0] b;
        b = LINE_W'(f) * LINE_W'(LINES_PER_FRAME);
        return fsr_pkg::IDX_W'(b);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        line_next       = line_reg;
        scan_cnt_next   = scan_cnt_reg;
        best_next       = best_reg;
        best_time_next  = best_time_reg;
        best_ok_next    = best_ok_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        clock_next      = clock_reg;
        policy_next     = cfg.valid ? cfg.replacement_policy : policy_reg;
        row_valid_next  = row_valid_reg;
        out_valid_next  = rsp.ready ? 1'b0 : out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = rd_addr_q_reg;
        wr_data         = '0;
        new_used        = row_used;
        new_acc         = row_acc;
        new_load        = row_load;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    mode_next = req.mode;
                    line_next = req.line_index;
                    res_next  = '0;
                    if (req.mode == fsr_pkg::MODE_FIND || req.mode == fsr_pkg::MODE_EVICT)
                    begin
                        if (NUM_FRAMES == 0)
                        begin
                            status_next = fsr_pkg::STATUS_NO_FRAME;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            scan_cnt_next = '0;
                            best_ok_next  = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    else if (32'(req.line_index) >= NUM_LINES)
                    begin
                        status_next = fsr_pkg::STATUS_BAD_LINE;
                        state_next  = S_DONE;
                    end
                    else if (32'(req.line_index) >= FULL_LINES)
                    begin
                        // line outside every complete frame: only the clock moves
                        clock_next  = stamp_one;
                        res_next    = req.line_index;
                        status_next = fsr_pkg::STATUS_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = frame_lut[req.line_index];
                        state_next = S_RMW;
                    end
                end
            end

            S_SCAN:
            begin
                if (32'(scan_cnt_reg) < NUM_FRAMES)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_cnt_reg[FRAME_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (mode_reg == fsr_pkg::MODE_FIND)
                begin
                    if (rd_pend_reg && row_used == '0)
                    begin
                        res_next    = frame_base(rd_addr_q_reg);
                        status_next = fsr_pkg::STATUS_OK;
                        state_next  = S_DONE;
                    end
                    else if (scan_last)
                    begin
                        res_next    = '0;
                        status_next = fsr_pkg::STATUS_NO_FRAME;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    if (rd_pend_reg && (!best_ok_reg || cand_time < best_time_reg))
                    begin
                        best_next      = rd_addr_q_reg;
                        best_time_next = cand_time;
                        best_ok_next   = 1'b1;
                    end
                    if (scan_last)
                    begin
                        state_next = S_EVICT;
                    end
                end
            end

            S_EVICT:
            begin
                // first line of the victim takes the first new stamp
                wr_en                    = 1'b1;
                wr_addr                  = best_reg;
                wr_data                  = {{LINES_PER_FRAME{1'b0}}, stamp_one, stamp_one};
                row_valid_next[best_reg] = 1'b1;
                clock_next               = stamp_frame;
                res_next                 = frame_base(best_reg);
                status_next              = fsr_pkg::STATUS_OK;
                state_next               = S_DONE;
            end

            S_RMW:
            begin
                if (mode_reg == fsr_pkg::MODE_FILL)
                begin
                    new_used[off] = 1'b1;
                end
                if (off == '0)
                begin
                    new_acc = stamp_one;
                    if (mode_reg == fsr_pkg::MODE_FILL)
                    begin
                        new_load = stamp_one;
                    end
                end
                wr_en                         = 1'b1;
                wr_addr                       = rd_addr_q_reg;
                wr_data                       = {new_used, new_acc, new_load};
                row_valid_next[rd_addr_q_reg] = 1'b1;
                clock_next                    = stamp_one;
                res_next                      = line_reg;
                status_next                   = fsr_pkg::STATUS_OK;
                state_next                    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = res_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= fsr_pkg::MODE_FIND;
            line_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_addr_q_reg  <= '0;
            best_reg       <= '0;
            best_time_reg  <= '0;
            best_ok_reg    <= 1'b0;
            res_reg        <= '0;
            status_reg     <= fsr_pkg::STATUS_OK;
            clock_reg      <= '0;
            policy_reg     <= 1'b0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_status_reg <= fsr_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            line_reg       <= line_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_pend_reg    <= rd_en;
            if (rd_en)
            begin
                rd_valid_reg  <= row_valid_reg[rd_addr];
                rd_addr_q_reg <= rd_addr;
            end
            best_reg       <= best_next;
            best_time_reg  <= best_time_next;
            best_ok_reg    <= best_ok_next;
            res_reg        <= res_next;
            status_reg     <= status_next;
            clock_reg      <= clock_next;
            policy_reg     <= policy_next;
            row_valid_reg  <= row_valid_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `FSR_ASSERT(a_wr_in_range, wr_en |-> (32'(wr_addr) < NUM_FRAMES), "write beyond last frame")
    `FSR_ASSERT(a_clock_mono, 1'b1 |=> (clock_reg >= $past(clock_reg)), "access clock went back")
    `FSR_ASSERT(a_rmw_has_data, (state_reg == S_RMW) |-> rd_pend_reg, "update without read data")
    `FSR_ASSERT(a_bad_line_mode, bad_line_done |-> line_mode, "bad line status on search")

endmodule

// ===== test/frame_store_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module frame_store_replacement_top_tb;

    localparam int NUM_LINES       = fsr_pkg::NUM_LINES_DEF;
    localparam int LINES_PER_FRAME = fsr_pkg::LINES_PER_FRAME_DEF;
    localparam int NUM_FRAMES      = NUM_LINES / LINES_PER_FRAME;
    localparam int TIME_W          = fsr_pkg::TIME_BITS_DEF;
    localparam int IDX_W           = fsr_pkg::IDX_W;
    localparam int SETTLE_CYCLES   = NUM_FRAMES + 10;
    localparam int LONG_HOLD       = 300;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        fsr_pkg::mode_t     mode;
        logic [IDX_W-1:0]   line_index;
        logic [2:0]         gap;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0]   result_index;
        fsr_pkg::status_t   status;
    } outcome_t;

    logic clk;
    logic rst_n;

    fsr_cfg_if cfg_ch ();
    fsr_req_if req_ch ();
    fsr_rsp_if rsp_ch ();

    frame_store_replacement_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // frame store mirror
    logic              line_busy    [NUM_LINES];
    logic [TIME_W-1:0] line_touched [NUM_LINES];
    logic [TIME_W-1:0] line_loaded  [NUM_LINES];
    logic [TIME_W-1:0] stamp_clock;
    logic              victim_policy = 1'b0;

    request_t pending_requests [$];
    outcome_t awaited_outcomes [$];
    request_t next_req;
    outcome_t seen;
    outcome_t wanted;

    int       items_queued    = 0;
    int       items_accepted  = 0;
    int       results_checked = 0;
    int       mismatch_count  = 0;
    int       cycle_count     = 0;
    bit       long_hold_go    = 1'b0;
    bit       long_hold_done;
    int       long_hold_left;
    logic [2:0] send_gap;
    logic [2:0] rsp_wait;
    logic [2:0] stall_draw;

    function automatic logic [TIME_W-1:0] next_stamp();
        if (stamp_clock != {TIME_W{1'b1}})
            stamp_clock = stamp_clock + 1'b1;
        return stamp_clock;
    endfunction

    function automatic outcome_t apply_request(fsr_pkg::mode_t m, logic [IDX_W-1:0] idx);
        outcome_t          o;
        int                base;
        bit                all_free;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] best_t;
        o.result_index = '0;
        o.status       = fsr_pkg::STATUS_OK;
        base           = -1;
        best_t         = '0;
        case (m)
            fsr_pkg::MODE_FIND:
            begin
                for (int f = 0; f < NUM_FRAMES; f++)
                begin
                    all_free = 1'b1;
                    for (int k = 0; k < LINES_PER_FRAME; k++)
                        if (line_busy[f * LINES_PER_FRAME + k])
                            all_free = 1'b0;
                    if (all_free && base < 0)
                        base = f * LINES_PER_FRAME;
                end
                if (base < 0)
                    o.status = fsr_pkg::STATUS_NO_FRAME;
                else
                    o.result_index = IDX_W'(base);
            end
            fsr_pkg::MODE_EVICT:
            begin
                for (int f = 0; f < NUM_FRAMES; f++)
                begin
                    t = victim_policy ? line_loaded[f * LINES_PER_FRAME]
                                      : line_touched[f * LINES_PER_FRAME];
                    if (base < 0 || t < best_t)
                    begin
                        base   = f * LINES_PER_FRAME;
                        best_t = t;
                    end
                end
                if (base < 0)
                    o.status = fsr_pkg::STATUS_NO_FRAME;
                else
                begin
                    for (int k = 0; k < LINES_PER_FRAME; k++)
                    begin
                        t = next_stamp();
                        line_busy[base + k]    = 1'b0;
                        line_touched[base + k] = t;
                        line_loaded[base + k]  = t;
                    end
                    o.result_index = IDX_W'(base);
                end
            end
            default:
            begin
                if (idx >= NUM_LINES)
                    o.status = fsr_pkg::STATUS_BAD_LINE;
                else
                begin
                    t = next_stamp();
                    line_touched[idx] = t;
                    if (m == fsr_pkg::MODE_FILL)
                    begin
                        line_busy[idx]   = 1'b1;
                        line_loaded[idx] = t;
                    end
                    o.result_index = idx;
                end
            end
        endcase
        return o;
    endfunction

    task automatic push_req(input fsr_pkg::mode_t m, input logic [IDX_W-1:0] idx);
        request_t r;
        r.mode       = m;
        r.line_index = idx;
        r.gap        = !items_queued[5] ? 3'($urandom_range(0, 6)) : 3'd0;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    task automatic push_random();
        int               pick;
        fsr_pkg::mode_t   m;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            m = fsr_pkg::MODE_FILL;
        else if (pick < 13)
            m = fsr_pkg::MODE_ACCESS;
        else if (pick < 17)
            m = fsr_pkg::MODE_FIND;
        else
            m = fsr_pkg::MODE_EVICT;
        if ($urandom_range(0, 6) == 0)
            idx = IDX_W'($urandom_range(NUM_LINES, (1 << IDX_W) - 1));
        else
            idx = IDX_W'($urandom_range(0, NUM_LINES - 1));
        push_req(m, idx);
    endtask

    task automatic wait_until_idle();
        do
            @(posedge clk);
        while (items_accepted != items_queued || results_checked != items_queued);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_policy(input logic p);
        @(posedge clk);
        cfg_ch.valid              <= 1'b1;
        cfg_ch.replacement_policy <= p;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid  <= 1'b0;
        victim_policy = p;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // request driver and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.mode       <= fsr_pkg::MODE_FIND;
            req_ch.line_index <= '0;
            send_gap          <= '0;
            stamp_clock       = '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                line_busy[i]    = 1'b0;
                line_touched[i] = '0;
                line_loaded[i]  = '0;
            end
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_outcomes.push_back(apply_request(req_ch.mode, req_ch.line_index));
                items_accepted <= items_accepted + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1'b1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req          = pending_requests.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.mode       <= next_req.mode;
                    req_ch.line_index <= next_req.line_index;
                    send_gap          <= next_req.gap;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_left != 0)
            long_hold_left <= long_hold_left - 1;
        else if (long_hold_go && !long_hold_done)
        begin
            long_hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= '0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked <= results_checked + 1;
                seen.result_index = rsp_ch.result_index;
                seen.status       = rsp_ch.status;
                if (awaited_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: index %0d status %0d",
                                 seen.result_index, seen.status);
                end
                else
                begin
                    wanted = awaited_outcomes.pop_front();
                    if (seen.result_index !== wanted.result_index ||
                        seen.status !== wanted.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result %0d: expected index %0d status %0d, ",
                                      "got index %0d status %0d"},
                                     results_checked, wanted.result_index, wanted.status,
                                     seen.result_index, seen.status);
                    end
                end
                stall_draw = results_checked[6] ? 3'd0 : 3'($urandom_range(0, 6));
                rsp_wait     <= (stall_draw == 0) ? 3'd0 : stall_draw - 3'd1;
                rsp_ch.ready <= (stall_draw == 0) && (long_hold_left == 0);
            end
            else if (rsp_wait != 0)
            begin
                rsp_wait     <= rsp_wait - 1'b1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= (long_hold_left == 0);
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.replacement_policy = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_policy(1'b0);

        // all free at reset, then eviction with every time equal
        push_req(fsr_pkg::MODE_FIND, 5'd31);
        push_req(fsr_pkg::MODE_EVICT, 5'd0);
        push_req(fsr_pkg::MODE_FILL, 5'd0);
        push_req(fsr_pkg::MODE_FILL, 5'd17);
        push_req(fsr_pkg::MODE_FILL, 5'd31);
        push_req(fsr_pkg::MODE_FILL, 5'd18);
        push_req(fsr_pkg::MODE_ACCESS, 5'd18);
        push_req(fsr_pkg::MODE_ACCESS, 5'd31);
        push_req(fsr_pkg::MODE_ACCESS, 5'd17);
        push_req(fsr_pkg::MODE_ACCESS, 5'd0);
        push_req(fsr_pkg::MODE_FIND, 5'd0);
        push_req(fsr_pkg::MODE_FILL, 5'd3);
        push_req(fsr_pkg::MODE_FILL, 5'd6);
        push_req(fsr_pkg::MODE_FILL, 5'd9);
        push_req(fsr_pkg::MODE_FILL, 5'd12);
        push_req(fsr_pkg::MODE_FILL, 5'd15);
        // every frame holds a used line
        push_req(fsr_pkg::MODE_FIND, 5'd0);
        push_req(fsr_pkg::MODE_EVICT, 5'd31);
        push_req(fsr_pkg::MODE_EVICT, 5'd0);
        push_req(fsr_pkg::MODE_FIND, 5'd0);
        // access to a free line
        push_req(fsr_pkg::MODE_ACCESS, 5'd1);
        push_req(fsr_pkg::MODE_EVICT, 5'd0);
        wait_until_idle();

        long_hold_go = 1'b1;
        repeat (450) push_random();
        wait_until_idle();

        set_policy(1'b1);
        repeat (450) push_random();
        wait_until_idle();

        set_policy(1'b0);
        repeat (100) push_random();
        wait_until_idle();

        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
